[hw/rtl/tqu_pkg.sv]
// Package for the thread ready queue: request and status codes, field widths
// and the per-cell control bundle. Depends on nothing; every file imports it.
package tqu_pkg;

    localparam int REQ_W    = 2;
    localparam int ID_W     = 16;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 6;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_POP    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_LOOKUP = 2'd3
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Control that the queue sequencer sends to one storage cell.
    typedef struct packed {
        logic capture;    // register the compare result
        logic match_all;  // any valid entry matches (pop of the head)
        logic valid;      // cell holds a live entry
        logic write;      // take the appended entry
        logic shift;      // take the entry of the next cell towards the tail
    } cell_ctl_t;

endpackage

[hw/rtl/tqu_cell.sv]
// One storage cell of the queue: an id, a handle and a registered compare bit.
// Depends on tqu_pkg for the control bundle and the handle width.
module tqu_cell
    import tqu_pkg::*;
#(
    parameter int KEY_W = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cell_ctl_t           ctl,
    input  logic [KEY_W-1:0]    key,
    input  logic [HANDLE_W-1:0] new_handle,
    input  logic [KEY_W-1:0]    next_id,
    input  logic [HANDLE_W-1:0] next_handle,
    output logic [KEY_W-1:0]    id,
    output logic [HANDLE_W-1:0] handle,
    output logic                match
);

    logic [KEY_W-1:0]    id_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic                match_reg;
    logic                match_next;

    assign match_next = ctl.valid && (ctl.match_all || (id_reg == key));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctl.capture)
        begin
            match_reg <= match_next;
        end
    end

    // Payload needs no reset: a cell beyond the fill count is never reported.
    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            id_reg     <= key;
            handle_reg <= new_handle;
        end
        else if (ctl.shift)
        begin
            id_reg     <= next_id;
            handle_reg <= next_handle;
        end
    end

    assign id     = id_reg;
    assign handle = handle_reg;
    assign match  = match_reg;

endmodule

[hw/rtl/thread_ready_queue_unit.sv]
// Top level of the thread ready queue: sequencer, fill count and a row of
// tqu_cell storage cells. Depends on tqu_pkg and tqu_cell.
//
// Use of the block:
//   Requests arrive on the s_axis channel: s_axis_tuser carries the request
//   kind (append, pop head, remove by id, look up by id) and s_axis_tdata the
//   thread id and the control-block handle. Every request gives exactly one
//   result on the m_axis channel: m_axis_tuser carries the status (ok, not
//   found or empty, full) and m_axis_tdata the id and handle found (zero
//   on append or a miss) plus the occupancy after the request.
//   In the cycle a request is accepted, every cell compares its id with the
//   key at once and registers the outcome; in the S_EXEC state a prefix
//   chain over those bits marks the first hit, the hit entry is read out,
//   and on pop or remove every cell from the hit onwards takes its
//   neighbour's entry, closing the gap in one step. A new request is taken
//   only once the previous one has finished its compare-then-shift pass
//   through the cell row.
//   The result sits in an output register, so a new request is taken while
//   an earlier result still waits. If the receiver stalls and a second
//   result is ready, the S_EXEC step is held until the first is taken.
//   Reset empties the queue (fill count zero) and drops any pending result;
//   the cell contents are not cleared, as cells beyond the count are never read.
module thread_ready_queue_unit
    import tqu_pkg::*;
#(
    parameter int DEPTH   = 32,
    parameter int ID_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] thread_id, [31:16] entry_handle
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] found_id, [31:16] found_handle,
                                        // [37:32] occupancy, [39:38] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    // Only the low ID_BITS bits of an id are kept, and never more than the port.
    localparam int KEY_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                state_reg,  state_next;
    logic [CNT_W-1:0]      count_reg,  count_next;
    req_kind_t             req_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [HANDLE_W-1:0]   handle_reg;
    logic                  out_valid_reg, out_valid_next;
    status_t               status_reg, status_next;
    logic [ID_W-1:0]       found_id_reg, found_id_next;
    logic [HANDLE_W-1:0]   found_handle_reg, found_handle_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;

    logic                  in_fire;
    logic                  exec_go;
    logic [KEY_W-1:0]      in_key;
    logic [KEY_W-1:0]      cell_key;

    cell_ctl_t             ctl      [DEPTH];
    logic [KEY_W-1:0]      cell_id  [DEPTH];
    logic [HANDLE_W-1:0]   cell_hdl [DEPTH];
    logic [DEPTH-1:0]      match;
    logic [DEPTH-1:0]      seen;      // a hit at or before this cell
    logic [DEPTH-1:0]      first;     // the hit nearest the head
    logic                  hit;
    logic                  full;
    logic                  is_take;   // pop or remove
    logic [KEY_W-1:0]      sel_id;
    logic [HANDLE_W-1:0]   sel_hdl;
    logic [CNT_W+OCC_W-1:0] count_ext;

    assign in_key   = s_axis_tdata[KEY_W-1:0];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    // The S_EXEC step may proceed once the output register is free or freeing.
    assign exec_go  = (state_reg == S_EXEC) && (!out_valid_reg || m_axis_tready);

    // During the accept cycle the cells compare against the incoming id.
    assign cell_key = (state_reg == S_IDLE) ? in_key : key_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign is_take = (req_reg == REQ_POP) || (req_reg == REQ_REMOVE);

    // First-hit marking over the registered compare bits.
    always_comb
    begin
        seen[0]  = match[0];
        first[0] = match[0];
        for (int k = 1; k < DEPTH; k++)
        begin
            seen[k]  = seen[k-1] | match[k];
            first[k] = match[k] & ~seen[k-1];
        end
    end
    assign hit = seen[DEPTH-1];

    // Read-out of the first hit: an AND-OR over the cells.
    always_comb
    begin
        sel_id  = '0;
        sel_hdl = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (first[k])
            begin
                sel_id  = sel_id  | cell_id[k];
                sel_hdl = sel_hdl | cell_hdl[k];
            end
        end
    end

    // Per-cell control.
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            ctl[k].capture   = in_fire;
            ctl[k].match_all = (s_axis_tuser == REQ_POP);
            ctl[k].valid     = (count_reg > CNT_W'(k));
            ctl[k].write     = exec_go && (req_reg == REQ_APPEND) && !full
                               && (count_reg == CNT_W'(k));
            ctl[k].shift     = exec_go && is_take && seen[k];
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [KEY_W-1:0]    nb_id;
            logic [HANDLE_W-1:0] nb_hdl;

            if (g == DEPTH - 1)
            begin : g_tail
                assign nb_id  = '0;
                assign nb_hdl = '0;
            end
            else
            begin : g_mid
                assign nb_id  = cell_id[g+1];
                assign nb_hdl = cell_hdl[g+1];
            end

            tqu_cell #(
                .KEY_W (KEY_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl[g]),
                .key         (cell_key),
                .new_handle  (handle_reg),
                .next_id     (nb_id),
                .next_handle (nb_hdl),
                .id          (cell_id[g]),
                .handle      (cell_hdl[g]),
                .match       (match[g])
            );
        end
    endgenerate

    // Result and next state of the sequencer.
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        found_id_next     = found_id_reg;
        found_handle_next = found_handle_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            state_next = S_EXEC;
        end

        if (exec_go)
        begin
            state_next        = S_IDLE;
            out_valid_next    = 1'b1;
            found_id_next     = '0;
            found_handle_next = '0;
            if (req_reg == REQ_APPEND)
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_OK;
                    count_next  = count_reg + 1'b1;
                end
            end
            else if (hit)
            begin
                status_next       = ST_OK;
                found_id_next     = ID_W'(sel_id);
                found_handle_next = sel_hdl;
                if (is_take)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            else
            begin
                status_next = ST_MISS;
            end
        end
    end

    assign count_ext = {{OCC_W{1'b0}}, count_next};
    assign occ_next  = count_ext[OCC_W-1:0];

    // Sequencer state, fill count and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
            status_reg       <= ST_OK;
            found_id_reg     <= '0;
            found_handle_reg <= '0;
            occ_reg          <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (exec_go)
            begin
                status_reg       <= status_next;
                found_id_reg     <= found_id_next;
                found_handle_reg <= found_handle_next;
                occ_reg          <= occ_next;
            end
        end
    end

    // Request payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg    <= req_kind_t'(s_axis_tuser);
            key_reg    <= in_key;
            handle_reg <= s_axis_tdata[ID_W +: HANDLE_W];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {2'b00, occ_reg, found_handle_reg, found_id_reg};

endmodule
